/* rtl/tcse_pkg.sv */
package tcse_pkg;

  // Parse phases, one per field of the record and ClientHello header
  typedef enum logic [4:0] {
    PH_TYPE    = 5'd0,
    PH_RVER    = 5'd1,
    PH_RLEN    = 5'd2,
    PH_HTYPE   = 5'd3,
    PH_HLEN    = 5'd4,
    PH_CVER    = 5'd5,
    PH_RANDOM  = 5'd6,
    PH_SIDLEN  = 5'd7,
    PH_SID     = 5'd8,
    PH_CSLEN   = 5'd9,
    PH_CS      = 5'd10,
    PH_CMLEN   = 5'd11,
    PH_CM      = 5'd12,
    PH_EXTLEN  = 5'd13,
    PH_EXTTYPE = 5'd14,
    PH_SNIHDR  = 5'd15,
    PH_NAMELEN = 5'd16,
    PH_NAME    = 5'd17,
    PH_STOP    = 5'd18
  } phase_t;

  // Status codes reported with the last beat
  localparam logic [2:0] ST_FOUND = 3'd0;
  localparam logic [2:0] ST_NOSNI = 3'd1;
  localparam logic [2:0] ST_NOTHS = 3'd2;
  localparam logic [2:0] ST_NOTCH = 3'd3;
  localparam logic [2:0] ST_TRUNC = 3'd4;

  localparam logic [7:0]  TYPE_HANDSHAKE   = 8'h16;
  localparam logic [7:0]  TYPE_CLIENTHELLO = 8'h01;
  localparam logic [15:0] RANDOM_BYTES     = 16'd32;
  localparam logic [15:0] SNI_HEADER_BYTES = 16'd5;

  // One result beat
  typedef struct packed {
    logic        name_valid;
    logic [7:0]  name_byte;
    logic [15:0] name_index;
    logic        done_res;
    logic [2:0]  status;
    logic [15:0] name_length;
    logic [7:0]  record_version_major;
    logic [7:0]  record_version_minor;
    logic [7:0]  client_version_major;
    logic [7:0]  client_version_minor;
    logic [15:0] record_length;
    logic [23:0] handshake_length;
  } sni_res_t;

endpackage

/* rtl/tcse_parser.sv */
module tcse_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output logic              res_present,
  output tcse_pkg::sni_res_t res
);
  import tcse_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  off_r, off_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic [15:0] nlen_r, nlen_nxt;
  logic [15:0] npos_r, npos_nxt;
  logic [2:0]  st_r, st_nxt;
  logic [7:0]  ver_r [4];
  logic [7:0]  ver_nxt [4];
  logic [15:0] rlen_r, rlen_nxt;
  logic [23:0] hlen_r, hlen_nxt;

  // scratch for the phase update
  logic        emit;
  logic        jump;
  phase_t      jump_ph;
  logic        skip_set;
  logic [15:0] skip_val;
  logic [1:0]  off_inc;
  logic [15:0] word;
  logic [15:0] skip_dec;
  logic        skip_done;
  logic [15:0] npos_inc;
  logic [15:0] nlen_word;

  // Phase update for one byte
  always_comb begin
    phase_nxt = phase_r;
    off_nxt   = off_r;
    skip_nxt  = skip_r;
    nlen_nxt  = nlen_r;
    npos_nxt  = npos_r;
    st_nxt    = st_r;
    ver_nxt   = ver_r;
    rlen_nxt  = rlen_r;
    hlen_nxt  = hlen_r;
    emit      = 1'b0;
    jump      = 1'b0;
    jump_ph   = phase_r;
    skip_set  = 1'b0;
    skip_val  = '0;
    off_inc   = off_r + 2'd1;
    word      = {skip_r[7:0], data_byte};
    skip_dec  = (skip_r != 16'd0) ? skip_r - 16'd1 : 16'd0;
    skip_done = (skip_dec == 16'd0);
    npos_inc  = npos_r + 16'd1;
    nlen_word = {nlen_r[7:0], data_byte};

    unique case (phase_r)
      PH_TYPE: begin
        jump = 1'b1;
        if (data_byte == TYPE_HANDSHAKE) begin
          jump_ph = PH_RVER;
        end else begin
          jump_ph = PH_STOP;
          st_nxt  = ST_NOTHS;
        end
      end
      PH_RVER: begin
        ver_nxt[{1'b0, off_r[0]}] = data_byte;
        off_nxt = off_inc;
        if (off_inc >= 2'd2) begin
          jump = 1'b1; jump_ph = PH_RLEN;
        end
      end
      PH_RLEN: begin
        rlen_nxt = {rlen_r[7:0], data_byte};
        off_nxt  = off_inc;
        if (off_inc >= 2'd2) begin
          jump = 1'b1; jump_ph = PH_HTYPE;
        end
      end
      PH_HTYPE: begin
        jump = 1'b1;
        if (data_byte == TYPE_CLIENTHELLO) begin
          jump_ph = PH_HLEN;
        end else begin
          jump_ph = PH_STOP;
          st_nxt  = ST_NOTCH;
        end
      end
      PH_HLEN: begin
        hlen_nxt = {hlen_r[15:0], data_byte};
        off_nxt  = off_inc;
        if (off_inc == 2'd3) begin
          jump = 1'b1; jump_ph = PH_CVER;
        end
      end
      PH_CVER: begin
        ver_nxt[{1'b1, off_r[0]}] = data_byte;
        off_nxt = off_inc;
        if (off_inc >= 2'd2) begin
          jump = 1'b1; jump_ph = PH_RANDOM;
          skip_set = 1'b1; skip_val = RANDOM_BYTES;
        end
      end
      PH_RANDOM, PH_SID, PH_CS, PH_CM, PH_SNIHDR: begin
        skip_nxt = skip_dec;
        if (skip_done) begin
          jump = 1'b1;
          unique case (phase_r)
            PH_RANDOM: jump_ph = PH_SIDLEN;
            PH_SID:    jump_ph = PH_CSLEN;
            PH_CS:     jump_ph = PH_CMLEN;
            PH_CM:     jump_ph = PH_EXTLEN;
            default:   jump_ph = PH_NAMELEN;
          endcase
        end
      end
      PH_SIDLEN, PH_CMLEN: begin
        // one-byte length prefix; zero skips nothing
        jump = 1'b1;
        if (data_byte == 8'd0) begin
          jump_ph = (phase_r == PH_SIDLEN) ? PH_CSLEN : PH_EXTLEN;
        end else begin
          jump_ph  = (phase_r == PH_SIDLEN) ? PH_SID : PH_CM;
          skip_set = 1'b1;
          skip_val = {8'd0, data_byte};
        end
      end
      PH_CSLEN: begin
        skip_nxt = word;
        off_nxt  = off_inc;
        if (off_inc >= 2'd2) begin
          jump = 1'b1;
          if (word == 16'd0) begin
            jump_ph = PH_CMLEN;
          end else begin
            jump_ph = PH_CS; skip_set = 1'b1; skip_val = word;
          end
        end
      end
      PH_EXTLEN: begin
        skip_nxt = word;
        off_nxt  = off_inc;
        if (off_inc >= 2'd2) begin
          jump = 1'b1; jump_ph = PH_EXTTYPE;
        end
      end
      PH_EXTTYPE: begin
        skip_nxt = word;
        off_nxt  = off_inc;
        if (off_inc >= 2'd2) begin
          jump = 1'b1;
          if (word == 16'd0) begin
            jump_ph = PH_SNIHDR; skip_set = 1'b1; skip_val = SNI_HEADER_BYTES;
          end else begin
            jump_ph = PH_STOP; st_nxt = ST_NOSNI;
          end
        end
      end
      PH_NAMELEN: begin
        nlen_nxt = nlen_word;
        off_nxt  = off_inc;
        if (off_inc >= 2'd2) begin
          npos_nxt = '0;
          jump     = 1'b1;
          if (nlen_word == 16'd0) begin
            jump_ph = PH_STOP; st_nxt = ST_FOUND;
          end else begin
            jump_ph = PH_NAME;
          end
        end
      end
      PH_NAME: begin
        emit     = 1'b1;
        npos_nxt = npos_inc;
        if (npos_inc >= nlen_r) begin
          jump = 1'b1; jump_ph = PH_STOP; st_nxt = ST_FOUND;
        end
      end
      default: begin
        // stopped: ignore bytes until the last one
      end
    endcase

    if (jump) begin
      phase_nxt = jump_ph;
      off_nxt   = '0;
      skip_nxt  = skip_set ? skip_val : 16'd0;
    end
  end

  // Result beat built from the updated fields
  always_comb begin
    res_present              = emit || last_byte;
    res                      = '0;
    res.name_valid           = emit;
    res.name_byte            = emit ? data_byte : 8'd0;
    res.name_index           = emit ? npos_r : 16'd0;
    if (last_byte) begin
      res.done_res             = 1'b1;
      res.status               = st_nxt;
      res.name_length          = nlen_nxt;
      res.record_version_major = ver_nxt[0];
      res.record_version_minor = ver_nxt[1];
      res.client_version_major = ver_nxt[2];
      res.client_version_minor = ver_nxt[3];
      res.record_length        = rlen_nxt;
      res.handshake_length     = hlen_nxt;
    end
  end

  // Parser state; the last beat of a record returns it to reset
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && last_byte)) begin
      phase_r <= PH_TYPE;
      off_r   <= '0;
      skip_r  <= '0;
      nlen_r  <= '0;
      npos_r  <= '0;
      st_r    <= ST_TRUNC;
      ver_r   <= '{default: 8'd0};
      rlen_r  <= '0;
      hlen_r  <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      skip_r  <= skip_nxt;
      nlen_r  <= nlen_nxt;
      npos_r  <= npos_nxt;
      st_r    <= st_nxt;
      ver_r   <= ver_nxt;
      rlen_r  <= rlen_nxt;
      hlen_r  <= hlen_nxt;
    end
  end

  // a finished record leaves the parser at the record type
  a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    fire && last_byte |=> phase_r == PH_TYPE && st_r == ST_TRUNC)
    else $error("parser not back at record start after last beat");

  // a name byte is only taken in the name phase, below the declared length
  a_name_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_NAME |-> npos_r < nlen_r)
    else $error("name position beyond declared name length");

  // stopped phase always carries a decided status
  a_stop_status: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_STOP |-> st_r != ST_TRUNC)
    else $error("stopped without a decided status");

endmodule

/* rtl/tls_client_hello_sni_extractor_core.sv */
// TLS ClientHello server-name extractor.
//
// Input channel: one record byte per beat on in_data_byte, in_last_byte high
// on the final byte. A beat is taken when in_valid is high and in_stall low.
// Result channel: a beat is offered for every name byte and for the last
// byte of a record (one beat if both). out_done_res marks the record summary
// with status, name length and the captured header fields.
//
// Each byte taken is held in the input register, parsed from there, and its
// result is captured in the result register that drives the out_ ports.
// Throughput: one byte per cycle while out_stall lets the result register drain,
// set by the single parse stage; the input register can take one more byte while a result waits to be taken.
// When out_stall is high with a result pending, the parse stage holds and
// in_stall rises as soon as the input register is occupied.
// Reset (rst_n low, synchronous) empties both registers and puts the parser
// at the record type byte; it also returns there after every last byte.
module tls_client_hello_sni_extractor_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_name_valid,
  output logic [7:0]  out_name_byte,
  output logic [15:0] out_name_index,
  output logic        out_done_res,
  output logic [2:0]  out_status,
  output logic [15:0] out_name_length,
  output logic [7:0]  out_record_version_major,
  output logic [7:0]  out_record_version_minor,
  output logic [7:0]  out_client_version_major,
  output logic [7:0]  out_client_version_minor,
  output logic [15:0] out_record_length,
  output logic [23:0] out_handshake_length
);
  import tcse_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       out_valid_r;
  sni_res_t   res_r;
  sni_res_t   res;
  logic       res_present;
  logic       adv;
  logic       fire;
  logic       in_take;

  // parse stage moves when the result register is free or being drained
  assign adv      = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  tcse_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .data_byte  (s1_byte_r),
    .last_byte  (s1_last_r),
    .res_present(res_present),
    .res        (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fire && res_present;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_present) begin
      res_r <= res;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_name_valid           = res_r.name_valid;
  assign out_name_byte            = res_r.name_byte;
  assign out_name_index           = res_r.name_index;
  assign out_done_res             = res_r.done_res;
  assign out_status               = res_r.status;
  assign out_name_length          = res_r.name_length;
  assign out_record_version_major = res_r.record_version_major;
  assign out_record_version_minor = res_r.record_version_minor;
  assign out_client_version_major = res_r.client_version_major;
  assign out_client_version_minor = res_r.client_version_minor;
  assign out_record_length        = res_r.record_length;
  assign out_handshake_length     = res_r.handshake_length;

  // every result beat carries a name byte or the record summary
  a_beat_has_content: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> res_r.name_valid || res_r.done_res)
    else $error("empty result beat");

  // summary fields are zero on a name-only beat
  a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.done_res |-> res_r.status == ST_FOUND
      && res_r.name_length == 16'd0 && res_r.handshake_length == 24'd0)
    else $error("summary fields set without done");

  // a stalled pending result never lets the parse stage advance
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !fire)
    else $error("parse stage advanced over a stalled result");

  // status stays within the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.done_res |-> res_r.status == ST_FOUND
      || res_r.status == ST_NOSNI || res_r.status == ST_NOTHS
      || res_r.status == ST_NOTCH || res_r.status == ST_TRUNC)
    else $error("undefined status code");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import tcse_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_name_valid;
  logic [7:0]  out_name_byte;
  logic [15:0] out_name_index;
  logic        out_done_res;
  logic [2:0]  out_status;
  logic [15:0] out_name_length;
  logic [7:0]  out_record_version_major;
  logic [7:0]  out_record_version_minor;
  logic [7:0]  out_client_version_major;
  logic [7:0]  out_client_version_minor;
  logic [15:0] out_record_length;
  logic [23:0] out_handshake_length;

  tls_client_hello_sni_extractor_core u_top (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_data_byte             (in_data_byte),
    .in_last_byte             (in_last_byte),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_name_valid           (out_name_valid),
    .out_name_byte            (out_name_byte),
    .out_name_index           (out_name_index),
    .out_done_res             (out_done_res),
    .out_status               (out_status),
    .out_name_length          (out_name_length),
    .out_record_version_major (out_record_version_major),
    .out_record_version_minor (out_record_version_minor),
    .out_client_version_major (out_client_version_major),
    .out_client_version_minor (out_client_version_minor),
    .out_record_length        (out_record_length),
    .out_handshake_length     (out_handshake_length)
  );

  // Shared state of sender, receiver and checker
  sni_res_t    sni_beats_due[$];
  logic [7:0]  rec_buf[$];
  int          src_idle_pct;
  int          snk_stall_pct;
  int          hold_req;
  int          bytes_sent;
  int          mismatch_cnt;
  sni_res_t    want_beat;
  sni_res_t    got_beat;

  // Parser mirror
  phase_t      prs_phase;
  logic [15:0] prs_off;
  logic [15:0] prs_span;
  logic [15:0] prs_name_len;
  logic [15:0] prs_name_pos;
  logic [2:0]  prs_status;
  logic [7:0]  prs_ver [4];
  logic [15:0] prs_rec_len;
  logic [23:0] prs_hs_len;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void goto_phase(input phase_t ph);
    prs_phase = ph;
    prs_off   = '0;
    prs_span  = '0;
  endfunction

  function automatic void parser_clear();
    goto_phase(PH_TYPE);
    prs_name_len = '0;
    prs_name_pos = '0;
    prs_status   = ST_TRUNC;
    for (int i = 0; i < 4; i++) prs_ver[i] = '0;
    prs_rec_len  = '0;
    prs_hs_len   = '0;
  endfunction

  // Length-prefixed span; an empty one goes straight to the next field
  function automatic void start_span(input logic [15:0] n, input phase_t skip_ph,
                                     input phase_t after);
    if (n == 0) begin
      goto_phase(after);
    end else begin
      goto_phase(skip_ph);
      prs_span = n;
    end
  endfunction

  function automatic void conclude(input logic [2:0] st);
    prs_status = st;
    goto_phase(PH_STOP);
  endfunction

  function automatic bit shift_word(input logic [7:0] b);
    prs_span = {prs_span[7:0], b};
    prs_off++;
    return prs_off >= 2;
  endfunction

  function automatic bit count_down();
    if (prs_span > 0) prs_span--;
    return prs_span == 0;
  endfunction

  // One record byte through the parser; 1 when it yields a result beat
  function automatic bit sni_parse_byte(input logic [7:0] b, input logic lst,
                                        output sni_res_t res);
    bit          emit;
    logic [7:0]  nb;
    logic [15:0] ni;
    emit = 1'b0;
    nb   = '0;
    ni   = '0;
    res  = '0;
    case (prs_phase)
      PH_TYPE: begin
        if (b == TYPE_HANDSHAKE) goto_phase(PH_RVER);
        else conclude(ST_NOTHS);
      end
      PH_RVER: begin
        prs_ver[prs_off[0]] = b;
        prs_off++;
        if (prs_off >= 2) goto_phase(PH_RLEN);
      end
      PH_RLEN: begin
        prs_rec_len = {prs_rec_len[7:0], b};
        prs_off++;
        if (prs_off >= 2) goto_phase(PH_HTYPE);
      end
      PH_HTYPE: begin
        if (b == TYPE_CLIENTHELLO) goto_phase(PH_HLEN);
        else conclude(ST_NOTCH);
      end
      PH_HLEN: begin
        prs_hs_len = {prs_hs_len[15:0], b};
        prs_off++;
        if (prs_off >= 3) goto_phase(PH_CVER);
      end
      PH_CVER: begin
        prs_ver[2 + prs_off[0]] = b;
        prs_off++;
        if (prs_off >= 2) start_span(RANDOM_BYTES, PH_RANDOM, PH_SIDLEN);
      end
      PH_RANDOM: if (count_down()) goto_phase(PH_SIDLEN);
      PH_SIDLEN: start_span({8'h00, b}, PH_SID, PH_CSLEN);
      PH_SID:    if (count_down()) goto_phase(PH_CSLEN);
      PH_CSLEN:  if (shift_word(b)) start_span(prs_span, PH_CS, PH_CMLEN);
      PH_CS:     if (count_down()) goto_phase(PH_CMLEN);
      PH_CMLEN:  start_span({8'h00, b}, PH_CM, PH_EXTLEN);
      PH_CM:     if (count_down()) goto_phase(PH_EXTLEN);
      PH_EXTLEN: if (shift_word(b)) goto_phase(PH_EXTTYPE);
      PH_EXTTYPE: begin
        if (shift_word(b)) begin
          if (prs_span == 0) start_span(SNI_HEADER_BYTES, PH_SNIHDR, PH_NAMELEN);
          else conclude(ST_NOSNI);
        end
      end
      PH_SNIHDR: if (count_down()) goto_phase(PH_NAMELEN);
      PH_NAMELEN: begin
        prs_name_len = {prs_name_len[7:0], b};
        prs_off++;
        if (prs_off >= 2) begin
          prs_name_pos = '0;
          if (prs_name_len == 0) conclude(ST_FOUND);
          else goto_phase(PH_NAME);
        end
      end
      PH_NAME: begin
        emit = 1'b1;
        nb   = b;
        ni   = prs_name_pos;
        prs_name_pos++;
        if (prs_name_pos >= prs_name_len) conclude(ST_FOUND);
      end
      default: ;
    endcase

    if (!emit && !lst) return 1'b0;

    res.name_valid = emit;
    res.name_byte  = nb;
    res.name_index = ni;
    if (lst) begin
      res.done_res             = 1'b1;
      res.status               = prs_status;
      res.name_length          = prs_name_len;
      res.record_version_major = prs_ver[0];
      res.record_version_minor = prs_ver[1];
      res.client_version_major = prs_ver[2];
      res.client_version_minor = prs_ver[3];
      res.record_length        = prs_rec_len;
      res.handshake_length     = prs_hs_len;
      parser_clear();
    end
    return 1'b1;
  endfunction

  // Record building
  function automatic void push_rand(input int n);
    for (int i = 0; i < n; i++) rec_buf.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void push_word(input logic [15:0] v);
    rec_buf.push_back(v[15:8]);
    rec_buf.push_back(v[7:0]);
  endfunction

  function automatic logic [7:0] byte_except(input logic [7:0] avoid);
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == avoid) b = 8'($urandom_range(255));
    return b;
  endfunction

  // ClientHello with random header content; name bytes sent may fall short
  function automatic void build_hello(input int sid_n, input logic [15:0] cs_n,
                                      input int cm_n, input logic [15:0] ext_type,
                                      input logic [15:0] name_decl, input int name_sent,
                                      input int tail_n);
    rec_buf.delete();
    rec_buf.push_back(TYPE_HANDSHAKE);
    push_rand(4);
    rec_buf.push_back(TYPE_CLIENTHELLO);
    push_rand(5 + 32);
    rec_buf.push_back(8'(sid_n));
    push_rand(sid_n);
    push_word(cs_n);
    push_rand(int'(cs_n));
    rec_buf.push_back(8'(cm_n));
    push_rand(cm_n);
    push_rand(2);
    push_word(ext_type);
    if (ext_type == 16'h0000) begin
      push_rand(5);
      push_word(name_decl);
      push_rand(name_sent);
    end
    push_rand(tail_n);
  endfunction

  // Sender: one beat, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic lst);
    sni_res_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= lst;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    bytes_sent++;
    if (sni_parse_byte(b, lst, res)) sni_beats_due.push_back(res);
  endtask

  // First n bytes of the buffer as one record
  task automatic send_record(input int n);
    if (n > rec_buf.size()) n = rec_buf.size();
    for (int i = 0; i < n; i++) send_byte(rec_buf[i], i == n - 1);
  endtask

  task automatic send_hello(input int sid_n, input logic [15:0] cs_n, input int cm_n,
                            input logic [15:0] ext_type, input logic [15:0] name_decl,
                            input int name_sent, input int tail_n);
    build_hello(sid_n, cs_n, cm_n, ext_type, name_decl, name_sent, tail_n);
    send_record(rec_buf.size());
  endtask

  // Short records: rejects, early ends and saturated header fields
  task automatic test_short_records();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(TYPE_HANDSHAKE, 1'b1);
    rec_buf = '{TYPE_HANDSHAKE, 8'h03, 8'h01, 8'h00, 8'h05, 8'h02, 8'hA5, 8'h5A};
    send_record(rec_buf.size());
    rec_buf = '{TYPE_HANDSHAKE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, TYPE_CLIENTHELLO,
                8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_record(rec_buf.size());
  endtask

  // Well-formed corner records
  task automatic test_hello_corners();
    src_idle_pct  = 12;
    snk_stall_pct = 12;
    // zero prefixes and an empty name, then trailing bytes ignored
    send_hello(0, 16'd0, 0, 16'h0000, 16'd0, 0, 3);
    send_hello(3, 16'd4, 1, 16'h0000, 16'd5, 5, 6);
    // first extension other than server name, in either byte
    send_hello(2, 16'd2, 1, 16'h0017, 16'd0, 0, 8);
    send_hello(1, 16'd2, 1, 16'h0100, 16'd0, 0, 2);
    // name cut one byte short
    build_hello(0, 16'd2, 1, 16'h0000, 16'd6, 6, 0);
    send_record(rec_buf.size() - 1);
    // a name longer than 255 bytes
    send_hello(4, 16'd6, 2, 16'h0000, 16'd257, 257, 1);
    // largest declared lengths, record ends early
    send_hello(255, 16'd2, 1, 16'h0000, 16'hFFFF, 12, 0);
    build_hello(1, 16'hFFFF, 1, 16'h0000, 16'd4, 4, 0);
    send_record(70);
  endtask

  // Random mix: mostly well-formed hellos, some cut short, plus rejects and noise
  task automatic test_random_records(input int n_bytes, input int src_pct,
                                     input int snk_pct);
    int base;
    int kind;
    int sid_n;
    int name_n;
    logic [15:0] ext_type;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    base = bytes_sent;
    while (bytes_sent - base < n_bytes) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        sid_n    = ($urandom_range(9) == 0) ? 32 : $urandom_range(0, 6);
        ext_type = ($urandom_range(7) == 0) ? 16'($urandom_range(65535)) : 16'h0000;
        name_n   = $urandom_range(0, 16);
        build_hello(sid_n, 16'($urandom_range(0, 10)), $urandom_range(0, 3), ext_type,
                    16'(name_n), name_n, $urandom_range(0, 4));
        if ($urandom_range(4) == 0) send_record($urandom_range(1, rec_buf.size()));
        else send_record(rec_buf.size());
      end else if (kind < 80) begin
        rec_buf.delete();
        rec_buf.push_back(byte_except(TYPE_HANDSHAKE));
        push_rand($urandom_range(0, 5));
        send_record(rec_buf.size());
      end else if (kind < 90) begin
        build_hello(0, 16'd1, 1, 16'h0000, 16'd3, 3, 0);
        rec_buf[5] = byte_except(TYPE_CLIENTHELLO);
        send_record($urandom_range(6, 14));
      end else begin
        rec_buf.delete();
        push_rand($urandom_range(1, 10));
        send_record(rec_buf.size());
      end
    end
  endtask

  // Receiver holds off while the sender keeps offering bytes
  task automatic test_backpressure();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_req      = HOLD_CYCLES;
    send_hello(2, 16'd4, 1, 16'h0000, 16'd9, 9, 2);
    send_hello(0, 16'd2, 0, 16'h0000, 16'd3, 3, 0);
  endtask

  // Receiver stall generation, long hold-off counted here
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < snk_stall_pct);
      end
    end
  end

  function automatic void note_fail(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("mismatch at %0t: %s", $time, msg);
  endfunction

  function automatic void check_field(input string fname, input logic [23:0] want,
                                      input logic [23:0] got);
    if (got !== want)
      note_fail($sformatf("%s expected %0h, got %0h", fname, want, got));
  endfunction

  // Result checker: payload is stable from the falling edge to the taking edge
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_beat = {out_name_valid, out_name_byte, out_name_index, out_done_res, out_status,
                  out_name_length, out_record_version_major, out_record_version_minor,
                  out_client_version_major, out_client_version_minor, out_record_length,
                  out_handshake_length};
      if (sni_beats_due.size() == 0) begin
        note_fail($sformatf("unexpected result beat %h", got_beat));
      end else begin
        want_beat = sni_beats_due.pop_front();
        check_field("name_valid", 24'(want_beat.name_valid), 24'(got_beat.name_valid));
        check_field("name_byte", 24'(want_beat.name_byte), 24'(got_beat.name_byte));
        check_field("name_index", 24'(want_beat.name_index), 24'(got_beat.name_index));
        check_field("done_res", 24'(want_beat.done_res), 24'(got_beat.done_res));
        check_field("status", 24'(want_beat.status), 24'(got_beat.status));
        check_field("name_length", 24'(want_beat.name_length),
                    24'(got_beat.name_length));
        check_field("record_version_major", 24'(want_beat.record_version_major),
                    24'(got_beat.record_version_major));
        check_field("record_version_minor", 24'(want_beat.record_version_minor),
                    24'(got_beat.record_version_minor));
        check_field("client_version_major", 24'(want_beat.client_version_major),
                    24'(got_beat.client_version_major));
        check_field("client_version_minor", 24'(want_beat.client_version_minor),
                    24'(got_beat.client_version_minor));
        check_field("record_length", 24'(want_beat.record_length),
                    24'(got_beat.record_length));
        check_field("handshake_length", want_beat.handshake_length,
                    got_beat.handshake_length);
      end
    end
  end

  // Watchdog: cycles with no beat taken on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("tls_client_hello_sni_extractor_core regression: fail");
    $finish;
  end

  // Test sequence
  initial begin
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_req      = 0;
    bytes_sent    = 0;
    mismatch_cnt  = 0;
    parser_clear();
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= 8'h00;
    in_last_byte <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_short_records();
    test_hello_corners();
    test_random_records(70, 0, 0);
    test_random_records(70, 54, 0);
    test_random_records(70, 0, 54);
    test_random_records(70, 12, 12);
    test_backpressure();
    in_valid <= 1'b0;

    // drain, then keep waiting to catch stray beats
    while (sni_beats_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("tls_client_hello_sni_extractor_core regression: pass");
    end else begin
      $display("tls_client_hello_sni_extractor_core regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/tcse_pkg.sv
rtl/tcse_parser.sv
rtl/tls_client_hello_sni_extractor_core.sv
verif/tb_top.sv
